// File: rtl/bll_pkg.sv
// ----------------------------------------------------------------------------
// bll_pkg: shared types and constants of the bounded linked list engine
// Command and status codes, sequencer states and the control and status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package bll_pkg;

   localparam int POOL_NODES_DEF = 64;
   localparam int FUNC_W         = 3;
   localparam int VALUE_W        = 31;
   localparam int POS_W          = 7;
   localparam int STATUS_W       = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_CLEAR    = 3'd0,
      FN_ADD_HEAD = 3'd1,
      FN_ADD_TAIL = 3'd2,
      FN_ADD_POS  = 3'd3,
      FN_REMOVE   = 3'd4,
      FN_LIST     = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_LINK,
      S_RM_CMP,
      S_LIST,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_WALK,
      RD_FIRST,
      RD_NEXT,
      RD_HOLD
   } rd_sel_type;

   typedef struct packed {
      logic       req_valid;
      func_type   func;
      logic       first_null;
      logic       full;
      logic       nx_null;
      logic       steps_done;
      logic       match;
      logic       next_null;
      logic       cnt_last;
      logic       slot_free;
   } stat_type;

   typedef struct packed {
      logic       ready;
      logic       start;
      logic       do_clear;
      logic       walk_adv;
      logic       node_wr;
      logic       link_fix;
      logic       unlink;
      logic       bump_taken;
      logic       scan_adv;
      logic       st_load;
      status_type st_code;
      logic       emit_list;
      logic       emit_st;
      rd_sel_type rd_sel;
   } ctrl_type;

endpackage

// File: rtl/bll_req_if.sv
// ----------------------------------------------------------------------------
// bll_req_if: command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface bll_req_if;
   logic                         valid;
   logic                         ready;
   logic [bll_pkg::FUNC_W-1:0]   func;
   logic [bll_pkg::VALUE_W-1:0]  value;
   logic [bll_pkg::POS_W-1:0]    position;

   modport source (output valid, func, value, position, input ready);
   modport sink (input valid, func, value, position, output ready);
endinterface

// File: rtl/bll_rsp_if.sv
// ----------------------------------------------------------------------------
// bll_rsp_if: result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface bll_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bll_pkg::VALUE_W-1:0]   item_value;
   logic [bll_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport source (output valid, item_value, status, last, input ready);
   modport sink (input valid, item_value, status, last, output ready);
endinterface

// File: rtl/bll_node_mem.sv
// ----------------------------------------------------------------------------
// bll_node_mem: node pool storage
// Value and link arrays of the node pool with one write port and one read
// port; read data is registered.
// ----------------------------------------------------------------------------
module bll_node_mem #(
   parameter int POOL_NODES = bll_pkg::POOL_NODES_DEF,
   localparam int IDX_W     = $clog2(POOL_NODES),
   localparam int LINK_W    = $clog2(POOL_NODES + 1)
) (
   input  logic                         clock,
   input  logic                         wr_val_en,
   input  logic                         wr_link_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [bll_pkg::VALUE_W-1:0]  wr_value,
   input  logic [LINK_W-1:0]            wr_link,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [bll_pkg::VALUE_W-1:0]  rd_value,
   output logic [LINK_W-1:0]            rd_link
);

   logic [bll_pkg::VALUE_W-1:0] value_mem [POOL_NODES];
   logic [LINK_W-1:0]           link_mem [POOL_NODES];

   always_ff @(posedge clock) begin
      if (wr_val_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_link_en) begin
         link_mem[wr_addr] <= wr_link;
      end
   end

   always_ff @(posedge clock) begin
      rd_value <= value_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
   end

endmodule

// File: rtl/bll_ctrl.sv
// ----------------------------------------------------------------------------
// bll_ctrl: command sequencer
// Steps one command through its walk, link update and result phases and
// drives the datapath one node per cycle unless a stalled result holds it.
// ----------------------------------------------------------------------------
module bll_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  bll_pkg::stat_type stat,
   output bll_pkg::ctrl_type ctrl
);

   bll_pkg::state_type state_ff;
   bll_pkg::state_type state_in;
   logic               list_end;

   assign list_end = stat.next_null | stat.cnt_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bll_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bll_pkg::S_IDLE: begin
            if (stat.req_valid) begin
               case (stat.func)
                  bll_pkg::FN_ADD_HEAD, bll_pkg::FN_ADD_TAIL, bll_pkg::FN_ADD_POS: begin
                     state_in = stat.full ? bll_pkg::S_RESP : bll_pkg::S_WALK;
                  end
                  bll_pkg::FN_REMOVE: begin
                     state_in = stat.first_null ? bll_pkg::S_RESP : bll_pkg::S_RM_CMP;
                  end
                  bll_pkg::FN_LIST: begin
                     state_in = stat.first_null ? bll_pkg::S_RESP : bll_pkg::S_LIST;
                  end
                  default: begin
                     state_in = bll_pkg::S_RESP;
                  end
               endcase
            end
         end
         bll_pkg::S_WALK: begin
            if (stat.steps_done || stat.nx_null) begin
               state_in = bll_pkg::S_LINK;
            end
         end
         bll_pkg::S_LINK: begin
            state_in = bll_pkg::S_RESP;
         end
         bll_pkg::S_RM_CMP: begin
            if (stat.match || list_end) begin
               state_in = bll_pkg::S_RESP;
            end
         end
         bll_pkg::S_LIST: begin
            if (stat.slot_free && list_end) begin
               state_in = bll_pkg::S_IDLE;
            end
         end
         bll_pkg::S_RESP: begin
            if (stat.slot_free) begin
               state_in = bll_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bll_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl         = '0;
      ctrl.st_code = bll_pkg::ST_OK;
      ctrl.rd_sel  = bll_pkg::RD_FIRST;
      case (state_ff)
         bll_pkg::S_IDLE: begin
            ctrl.ready = 1'b1;
            if (stat.req_valid) begin
               ctrl.start   = 1'b1;
               ctrl.st_load = 1'b1;
               case (stat.func)
                  bll_pkg::FN_CLEAR: begin
                     ctrl.do_clear = 1'b1;
                  end
                  bll_pkg::FN_ADD_HEAD, bll_pkg::FN_ADD_TAIL, bll_pkg::FN_ADD_POS: begin
                     if (stat.full) begin
                        ctrl.st_code = bll_pkg::ST_FULL;
                     end
                  end
                  bll_pkg::FN_REMOVE: begin
                     if (stat.first_null) begin
                        ctrl.st_code = bll_pkg::ST_NOT_FOUND;
                     end
                  end
                  bll_pkg::FN_LIST: begin
                     if (stat.first_null) begin
                        ctrl.st_code = bll_pkg::ST_EMPTY;
                     end
                  end
                  default: begin
                     ctrl.st_code = bll_pkg::ST_OK;
                  end
               endcase
            end
         end
         bll_pkg::S_WALK: begin
            ctrl.rd_sel = bll_pkg::RD_WALK;
            if (stat.steps_done || stat.nx_null) begin
               ctrl.node_wr = 1'b1;
            end else begin
               ctrl.walk_adv = 1'b1;
            end
         end
         bll_pkg::S_LINK: begin
            ctrl.link_fix   = 1'b1;
            ctrl.bump_taken = 1'b1;
         end
         bll_pkg::S_RM_CMP: begin
            ctrl.rd_sel = bll_pkg::RD_NEXT;
            if (stat.match) begin
               ctrl.link_fix = 1'b1;
               ctrl.unlink   = 1'b1;
               ctrl.st_load  = 1'b1;
            end else if (list_end) begin
               ctrl.st_load = 1'b1;
               ctrl.st_code = bll_pkg::ST_NOT_FOUND;
            end else begin
               ctrl.scan_adv = 1'b1;
            end
         end
         bll_pkg::S_LIST: begin
            if (stat.slot_free) begin
               ctrl.emit_list = 1'b1;
               ctrl.rd_sel    = bll_pkg::RD_NEXT;
               ctrl.scan_adv  = ~list_end;
            end else begin
               ctrl.rd_sel = bll_pkg::RD_HOLD;
            end
         end
         bll_pkg::S_RESP: begin
            ctrl.emit_st = stat.slot_free;
         end
         default: begin
            ctrl.rd_sel = bll_pkg::RD_FIRST;
         end
      endcase
   end

endmodule

// File: rtl/bounded_linked_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_linked_list_engine: singly linked list over a fixed node pool
// Keeps one ordered list in a pool of POOL_NODES nodes handed out in
// allocation order; commands clear, insert, remove and list the values.
//
//   Channel   Dir   Beat contents                   Beats per command
//   req_ch    in    func, value, position           one
//   rsp_ch    out   item_value, status, last        one, or one per node (list)
//
// A command is taken only while the sequencer is idle. Clear, unknown codes
// and a full pool go straight to the result; an add walks to its position,
// writes the node, then fixes the link; a remove compares node by node; a
// list emits one beat per node. The walk rate is set by the single read
// port of the node memory, one node per cycle. Reset empties the list at
// once with no clearing pass. A stalled result holds the sequencer in place.
// ----------------------------------------------------------------------------
module bounded_linked_list_engine #(
   parameter int POOL_NODES = bll_pkg::POOL_NODES_DEF
) (
   input logic         clock,
   input logic         reset,
   bll_req_if.sink     req_ch,
   bll_rsp_if.source   rsp_ch
);

   localparam int IDX_W  = $clog2(POOL_NODES);
   localparam int LINK_W = $clog2(POOL_NODES + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

   bll_pkg::stat_type stat;
   bll_pkg::ctrl_type ctrl;

   logic [LINK_W-1:0]            first_ff;
   logic [LINK_W-1:0]            taken_ff;
   logic [LINK_W-1:0]            at_ff;
   logic [LINK_W-1:0]            cur_ff;
   logic [LINK_W-1:0]            cnt_ff;
   logic [bll_pkg::VALUE_W-1:0]  value_ff;
   bll_pkg::status_type          st_ff;
   logic                         rsp_valid_ff;
   logic [bll_pkg::VALUE_W-1:0]  rsp_value_ff;
   bll_pkg::status_type          rsp_status_ff;
   logic                         rsp_last_ff;

   logic [bll_pkg::VALUE_W-1:0]  rd_value;
   logic [LINK_W-1:0]            rd_link;
   logic [IDX_W-1:0]             rd_addr;
   logic [LINK_W-1:0]            rd_full;
   logic [IDX_W-1:0]             wr_addr;
   logic [LINK_W-1:0]            wr_link;
   logic                         wr_link_en;

   logic                         at_nil;
   logic [LINK_W-1:0]            follow_at;
   logic [LINK_W-1:0]            nx_w;
   logic [LINK_W-1:0]            link_nx;
   logic [LINK_W-1:0]            link_src;
   logic [bll_pkg::POS_W-1:0]    pos_dec;
   logic [bll_pkg::POS_W-1:0]    pos_lim;
   logic [LINK_W-1:0]            steps;
   logic                         slot_free;
   bll_pkg::func_type            req_func;

   assign req_func  = bll_pkg::func_type'(req_ch.func);
   assign at_nil    = at_ff >= NIL;
   assign follow_at = at_nil ? first_ff : rd_link;
   assign nx_w      = (follow_at >= NIL) ? NIL : follow_at;
   assign link_nx   = (rd_link >= NIL) ? NIL : rd_link;
   assign link_src  = ctrl.unlink ? link_nx : taken_ff;
   assign slot_free = ~rsp_valid_ff | rsp_ch.ready;

   assign pos_dec = (req_ch.position > bll_pkg::POS_W'(1))
                    ? req_ch.position - bll_pkg::POS_W'(1) : '0;
   assign pos_lim = (pos_dec > bll_pkg::POS_W'(POOL_NODES))
                    ? bll_pkg::POS_W'(POOL_NODES) : pos_dec;

   always_comb begin
      case (req_func)
         bll_pkg::FN_ADD_TAIL: steps = NIL;
         bll_pkg::FN_ADD_POS:  steps = pos_lim[LINK_W-1:0];
         default:              steps = '0;
      endcase
   end

   always_comb begin
      case (ctrl.rd_sel)
         bll_pkg::RD_WALK: rd_full = nx_w;
         bll_pkg::RD_NEXT: rd_full = link_nx;
         bll_pkg::RD_HOLD: rd_full = cur_ff;
         default:          rd_full = first_ff;
      endcase
   end
   assign rd_addr = rd_full[IDX_W-1:0];

   assign wr_addr    = ctrl.node_wr ? taken_ff[IDX_W-1:0] : at_ff[IDX_W-1:0];
   assign wr_link    = ctrl.node_wr ? nx_w : link_src;
   assign wr_link_en = ctrl.node_wr | (ctrl.link_fix & ~at_nil);

   always_comb begin
      stat            = '0;
      stat.req_valid  = req_ch.valid;
      stat.func       = req_func;
      stat.first_null = first_ff >= NIL;
      stat.full       = taken_ff >= NIL;
      stat.nx_null    = nx_w == NIL;
      stat.steps_done = cnt_ff == '0;
      stat.match      = rd_value == value_ff;
      stat.next_null  = link_nx == NIL;
      stat.cnt_last   = cnt_ff == LINK_W'(POOL_NODES - 1);
      stat.slot_free  = slot_free;
   end

   bll_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   bll_node_mem #(
      .POOL_NODES (POOL_NODES)
   ) u_node_mem (
      .clock      (clock),
      .wr_val_en  (ctrl.node_wr),
      .wr_link_en (wr_link_en),
      .wr_addr    (wr_addr),
      .wr_value   (value_ff),
      .wr_link    (wr_link),
      .rd_addr    (rd_addr),
      .rd_value   (rd_value),
      .rd_link    (rd_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= NIL;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.do_clear) begin
            first_ff <= NIL;
            taken_ff <= '0;
         end
         if (ctrl.link_fix && at_nil) begin
            first_ff <= link_src;
         end
         if (ctrl.bump_taken) begin
            taken_ff <= taken_ff + LINK_W'(1);
         end
         if (ctrl.emit_list || ctrl.emit_st) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         at_ff    <= NIL;
         cur_ff   <= first_ff;
         cnt_ff   <= steps;
         value_ff <= req_ch.value;
      end
      if (ctrl.walk_adv) begin
         at_ff  <= nx_w;
         cnt_ff <= cnt_ff - LINK_W'(1);
      end
      if (ctrl.scan_adv) begin
         at_ff  <= cur_ff;
         cur_ff <= link_nx;
         cnt_ff <= cnt_ff + LINK_W'(1);
      end
      if (ctrl.st_load) begin
         st_ff <= ctrl.st_code;
      end
      if (ctrl.emit_list) begin
         rsp_value_ff  <= rd_value;
         rsp_status_ff <= bll_pkg::ST_OK;
         rsp_last_ff   <= stat.next_null | stat.cnt_last;
      end else if (ctrl.emit_st) begin
         rsp_value_ff  <= '0;
         rsp_status_ff <= st_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign req_ch.ready      = ctrl.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.item_value = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule
